// ----- hdl/hdlc_bit_receiver_macros.svh -----
// Assertion macros for the checker file of the HDLC bit receiver.
`ifndef HDLC_BIT_RECEIVER_MACROS_SVH
`define HDLC_BIT_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HBR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hbr_pkg.sv -----
// Types, codes and the CRC step shared by the HDLC bit receiver.
`default_nettype none
package hbr_pkg;

  localparam int unsigned KIND_WIDTH    = 3;
  localparam int unsigned MAX_LEN_WIDTH = 11;

  typedef logic [KIND_WIDTH-1:0]    kind_t;
  typedef logic [MAX_LEN_WIDTH-1:0] max_len_t;

  localparam kind_t KIND_DATA    = 3'd0;
  localparam kind_t KIND_GOOD    = 3'd1;
  localparam kind_t KIND_BAD     = 3'd2;
  localparam kind_t KIND_PARTIAL = 3'd3;
  localparam kind_t KIND_ABORT   = 3'd4;

  localparam max_len_t MAX_LEN_RESET = 11'd330;

  localparam logic [7:0]  FLAG_PATTERN = 8'h7E;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [2:0]  ONES_LIMIT   = 3'd5;

  // One symbol out of the flag window: a data bit or a flag.
  typedef struct packed {
    logic valid;
    logic flag;
    logic data;
  } sym_t;

  // Reflected CRC-16/X.25 over one octet, LSB first.
  function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hbr_line_if.sv -----
// Valid/ready channel carrying one received line bit per beat.
`default_nettype none
interface hbr_line_if;
  logic valid;
  logic ready;
  logic line_bit;

  modport source (output valid, output line_bit, input ready);
  modport sink   (input valid, input line_bit, output ready);
endinterface
`default_nettype wire

// ----- hdl/hbr_report_if.sv -----
// Valid/ready channel carrying one receiver report (octet or frame status) per beat.
`default_nettype none
interface hbr_report_if
  import hbr_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 11
);
  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic [7:0]              octet;
  logic [LENGTH_WIDTH-1:0] frame_length;

  modport source (output valid, output kind, output octet, output frame_length, input ready);
  modport sink   (input valid, input kind, input octet, input frame_length, output ready);
endinterface
`default_nettype wire

// ----- hdl/hdlc_bit_receiver.sv -----
// HDLC bit receiver top level: a line bit stream in, octets and frame status out, with
// flag detection, zero unstuffing and a CRC-16/X.25 check. One line bit is taken per
// cycle while the two-entry result buffer has space; its report, if any, waits there
// behind earlier ones for the report channel. Each symbol out of the look-ahead window
// passes the deframer in the same cycle and lands in that buffer, so line_bits.ready
// drops only while two reports wait unread. max_len may be written while no bits are
// being taken; the frame length is LENGTH_WIDTH bits wide and stops at its maximum.
`default_nettype none
module hdlc_bit_receiver
  import hbr_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 11
)(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_wr_en,
  input  wire  [10:0]         cfg_wr_data,
  hbr_line_if.sink            line_bits,
  hbr_report_if.source        reports
);

  localparam int unsigned RES_W = KIND_WIDTH + 8 + LENGTH_WIDTH;

  max_len_t                max_len;
  logic                    accept;
  logic                    buf_space;
  sym_t                    sym;
  logic                    res_valid;
  kind_t                   res_kind;
  logic [7:0]              res_octet;
  logic [LENGTH_WIDTH-1:0] res_length;
  logic [RES_W-1:0]        buf_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  assign line_bits.ready = buf_space;
  assign accept          = line_bits.valid && buf_space;

  hbr_window u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .line_bit (line_bits.line_bit),
    .sym      (sym)
  );

  hbr_deframer #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_deframer (
    .clk        (clk),
    .rst        (rst),
    .sym        (sym),
    .max_len    (max_len),
    .res_valid  (res_valid),
    .res_kind   (res_kind),
    .res_octet  (res_octet),
    .res_length (res_length)
  );

  hbr_out_buf #(
    .WIDTH (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_kind, res_octet, res_length}),
    .space     (buf_space),
    .valid     (reports.valid),
    .ready     (reports.ready),
    .data      (buf_data)
  );

  assign reports.kind         = buf_data[RES_W-1 -: KIND_WIDTH];
  assign reports.octet        = buf_data[LENGTH_WIDTH +: 8];
  assign reports.frame_length = buf_data[LENGTH_WIDTH-1:0];

endmodule
`default_nettype wire

// ----- hdl/hbr_window.sv -----
// Eight-bit look-ahead window that turns line bits into data-bit and flag symbols.
`default_nettype none
module hbr_window
  import hbr_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  accept,
  input  wire  line_bit,
  output sym_t sym
);

  logic [7:0] lookahead;
  logic [2:0] fill;
  logic [7:0] lookahead_next;
  logic [2:0] fill_next;
  logic [7:0] window;

  always_comb begin
    window         = lookahead | ((8'h01 << fill) & {8{line_bit}});
    sym            = '0;
    lookahead_next = lookahead;
    fill_next      = fill;
    if (accept) begin
      if (fill == 3'd7) begin
        sym.valid = 1'b1;
        if (window == FLAG_PATTERN) begin
          // Flag consumes the whole window.
          sym.flag       = 1'b1;
          lookahead_next = '0;
          fill_next      = '0;
        end else begin
          sym.data       = window[0];
          lookahead_next = window >> 1;
        end
      end else begin
        lookahead_next = window;
        fill_next      = fill + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= '0;
      fill      <= '0;
    end else begin
      lookahead <= lookahead_next;
      fill      <= fill_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hbr_deframer.sv -----
// Flag hunt, zero unstuffing, octet assembly and FCS check for the HDLC receiver.
`default_nettype none
module hbr_deframer
  import hbr_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 11
)(
  input  wire                     clk,
  input  wire                     rst,
  input  sym_t                    sym,
  input  max_len_t                max_len,
  output logic                    res_valid,
  output kind_t                   res_kind,
  output logic [7:0]              res_octet,
  output logic [LENGTH_WIDTH-1:0] res_length
);

  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_SYNC  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  localparam int unsigned CMP_W =
    (LENGTH_WIDTH > MAX_LEN_WIDTH) ? LENGTH_WIDTH : MAX_LEN_WIDTH;
  localparam logic [LENGTH_WIDTH-1:0] TOTAL_MAX = {LENGTH_WIDTH{1'b1}};

  logic [1:0]              mode, mode_next;
  logic [2:0]              bit_index, bit_index_next;
  logic [2:0]              ones_run, ones_run_next;
  logic                    stuff_pending, stuff_pending_next;
  logic [7:0]              shift_octet, shift_octet_next;
  logic [LENGTH_WIDTH-1:0] octet_total, octet_total_next;
  logic [15:0]             crc_lagged, crc_lagged_next;
  logic [15:0]             last_two, last_two_next;

  logic        do_frame;
  logic        finish;
  logic [15:0] fcs;

  always_comb begin
    mode_next          = mode;
    bit_index_next     = bit_index;
    ones_run_next      = ones_run;
    stuff_pending_next = stuff_pending;
    shift_octet_next   = shift_octet;
    octet_total_next   = octet_total;
    crc_lagged_next    = crc_lagged;
    last_two_next      = last_two;
    res_valid          = 1'b0;
    res_kind           = KIND_DATA;
    res_octet          = '0;
    res_length         = '0;
    do_frame           = 1'b0;
    finish             = 1'b0;
    fcs                = {~last_two[7:0], ~last_two[15:8]};

    if (sym.valid) begin
      case (mode)
        MODE_FRAME: do_frame = 1'b1;
        MODE_SYNC: begin
          if (!sym.flag) begin
            // First data bit after the opening flags: start a fresh frame.
            mode_next          = MODE_FRAME;
            bit_index_next     = '0;
            ones_run_next      = '0;
            stuff_pending_next = 1'b0;
            shift_octet_next   = '0;
            octet_total_next   = '0;
            crc_lagged_next    = CRC_INIT;
            last_two_next      = '0;
            do_frame           = 1'b1;
          end
        end
        default: mode_next = sym.flag ? MODE_SYNC : MODE_HUNT;
      endcase
    end

    if (do_frame) begin
      fcs = {~last_two_next[7:0], ~last_two_next[15:8]};
      if (stuff_pending_next) begin
        stuff_pending_next = 1'b0;
        if (sym.flag || sym.data) begin
          // Six ones in a row, or a flag where the stuffed zero should be: abort.
          mode_next  = MODE_HUNT;
          res_valid  = 1'b1;
          res_kind   = KIND_ABORT;
          res_length = octet_total_next;
        end else begin
          // Drop the stuffed zero; release an octet held behind it.
          ones_run_next = '0;
          finish        = (bit_index_next == 3'd0);
        end
      end else if (bit_index_next == 3'd0 && sym.flag) begin
        mode_next  = MODE_SYNC;
        res_valid  = 1'b1;
        res_kind   = (octet_total_next >= LENGTH_WIDTH'(2) && fcs == crc_lagged_next)
                     ? KIND_GOOD : KIND_BAD;
        res_length = octet_total_next;
      end else if (bit_index_next == 3'd0 &&
                   (CMP_W'(octet_total_next) > CMP_W'(max_len) ||
                    octet_total_next == TOTAL_MAX)) begin
        // Frame too long.
        mode_next  = MODE_HUNT;
        res_valid  = 1'b1;
        res_kind   = KIND_ABORT;
        res_length = octet_total_next;
      end else if (sym.flag) begin
        mode_next  = MODE_SYNC;
        res_valid  = 1'b1;
        res_kind   = KIND_PARTIAL;
        res_length = octet_total_next;
      end else begin
        shift_octet_next = {sym.data, shift_octet_next[7:1]};
        ones_run_next    = sym.data ? ones_run_next + 3'd1 : 3'd0;
        bit_index_next   = bit_index_next + 3'd1;
        if (ones_run_next >= ONES_LIMIT) begin
          stuff_pending_next = 1'b1;
        end else begin
          finish = (bit_index_next == 3'd0);
        end
      end

      if (finish) begin
        // CRC lags two octets behind so the FCS itself stays out of it.
        if (octet_total_next >= LENGTH_WIDTH'(2)) begin
          crc_lagged_next = crc16_x25_byte(crc_lagged_next, last_two_next[15:8]);
        end
        last_two_next = {last_two_next[7:0], shift_octet_next};
        if (octet_total_next != TOTAL_MAX) begin
          octet_total_next = octet_total_next + LENGTH_WIDTH'(1);
        end
        res_valid = 1'b1;
        res_kind  = KIND_DATA;
        res_octet = shift_octet_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_HUNT;
      bit_index     <= '0;
      ones_run      <= '0;
      stuff_pending <= 1'b0;
      shift_octet   <= '0;
      octet_total   <= '0;
      crc_lagged    <= CRC_INIT;
      last_two      <= '0;
    end else begin
      mode          <= mode_next;
      bit_index     <= bit_index_next;
      ones_run      <= ones_run_next;
      stuff_pending <= stuff_pending_next;
      shift_octet   <= shift_octet_next;
      octet_total   <= octet_total_next;
      crc_lagged    <= crc_lagged_next;
      last_two      <= last_two_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hbr_out_buf.sv -----
// Two-entry result register with skid slot between the deframer and the report channel.
`default_nettype none
module hbr_out_buf #(
  parameter int unsigned WIDTH = 22
)(
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire  [WIDTH-1:0] push_data,
  output logic             space,
  output logic             valid,
  input  wire              ready,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign valid = (count != 2'd0);
  assign space = (count != 2'd2);
  assign data  = entries[rd_ptr];
  assign pop   = valid && ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hbr_checker.sv -----
// Port-level checks on the HDLC bit receiver report channel, bound to the top level.
`default_nettype none
`include "hdlc_bit_receiver_macros.svh"
module hbr_checker
  import hbr_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 11
)(
  input wire                    clk,
  input wire                    rst,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire [KIND_WIDTH-1:0]   out_kind,
  input wire [7:0]              out_octet,
  input wire [LENGTH_WIDTH-1:0] out_length
);

  `HBR_ASSERT_NEXT(a_report_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_octet) && $stable(out_length), "report beat changed while stalled")
  `HBR_ASSERT_NOW(a_data_no_length, clk, rst, out_valid && out_kind == KIND_DATA, out_length == '0, "data octet beat carries a frame length")
  `HBR_ASSERT_NOW(a_status_no_octet, clk, rst, out_valid && out_kind != KIND_DATA, out_octet == 8'h00, "status beat carries an octet")
  `HBR_ASSERT_NOW(a_good_has_fcs, clk, rst, out_valid && out_kind == KIND_GOOD, out_length >= LENGTH_WIDTH'(2), "good frame shorter than its FCS")

endmodule

bind hdlc_bit_receiver hbr_checker #(
  .LENGTH_WIDTH (LENGTH_WIDTH)
) u_hbr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (reports.valid),
  .out_ready  (reports.ready),
  .out_kind   (reports.kind),
  .out_octet  (reports.octet),
  .out_length (reports.frame_length)
);
`default_nettype wire
